FILE: hw/rtl/dmwb_pkg.sv
// Shared definitions for the direct-mapped write-back tag controller.
// Command codes, default sizes and the per-request flag bundle.
// No dependencies.
package dmwb_pkg;

	localparam int SETS_DEF       = 32768;
	localparam int BLOCK_BITS_DEF = 23;
	localparam int CMD_W          = 2;

	localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SYNC   = 2'd3;

	// Outcome flags of one lookup
	typedef struct packed {
		logic hit;
		logic writeback;
		logic fetch;
	} dmwb_flags_t;

endpackage

FILE: hw/rtl/direct_mapped_writeback_tag_controller_unit.sv
// Top level of the direct-mapped write-back tag controller.
// Instantiates dmwb_tag_ram and dmwb_update; uses dmwb_pkg.
//
// Tag and dirty bookkeeping for a direct-mapped write-back block cache. Each
// request (cmd, block) looks up slot = block mod SETS and returns one response
// telling the data path whether the slot held the block (hit), whether the
// slot must first be written back to disk block writeback_block, and whether
// the requested block must be fetched. SETS must be a power of two, so the
// slot is the low block bits and the tag the bits above. The line state
// {valid, dirty, tag} lives in a single synchronous RAM with a registered read;
// each request makes one read-modify-write: the read is issued at the
// request transfer, the update is computed and written back when the request
// leaves the lookup stage, as the response is loaded into the output register.
// A request to the same slot that transfers while the previous one is written
// back takes the freshly written word through a forwarding register, so
// requests stream at one per cycle whenever the response side keeps taking;
// the response is registered and is valid once its request leaves the lookup
// stage. After reset a clearing sweep writes every line invalid, one line a
// cycle, so req_ready stays low until all SETS lines (32768 by default) clear.
module direct_mapped_writeback_tag_controller_unit
	import dmwb_pkg::*;
#(
	parameter int SETS       = SETS_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [BLOCK_BITS-1:0]    block,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic                     hit,
	output logic [$clog2(SETS)-1:0]  slot,
	output logic                     writeback,
	output logic [BLOCK_BITS-1:0]    writeback_block,
	output logic                     fetch
);

	localparam int SLOT_W = $clog2(SETS);
	localparam int TAG_W  = (BLOCK_BITS > SLOT_W) ? (BLOCK_BITS - SLOT_W) : 1;
	localparam int WORD_W = TAG_W + 2;

	// Request decode
	logic                  req_fire;
	logic [SLOT_W-1:0]     req_slot;
	logic [BLOCK_BITS-1:0] req_upper;
	logic [TAG_W-1:0]      req_tag;

	// Lookup stage
	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [TAG_W-1:0]      tag_s1;
	logic                  fwd_s1;
	logic [WORD_W-1:0]     fwd_word_s1;
	logic                  adv_s1;

	// RAM and update
	logic [WORD_W-1:0]     rd_word;
	logic [WORD_W-1:0]     cur_word;
	logic [WORD_W-1:0]     new_word;
	dmwb_flags_t           upd_flags;
	logic [BLOCK_BITS-1:0] upd_wb_block;
	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;

	// Clearing sweep
	logic                  clr_busy_q;
	logic [SLOT_W-1:0]     clr_cnt_q;

	// Response register
	logic                  rsp_valid_q;
	logic                  hit_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  writeback_q;
	logic [BLOCK_BITS-1:0] wb_block_q;
	logic                  fetch_q;

	assign req_slot  = block[SLOT_W-1:0];
	assign req_upper = block >> SLOT_W;
	assign req_tag   = req_upper[TAG_W-1:0];

	// Stage moves on when the response register is free or being drained
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign req_fire  = req_valid && req_ready;

	// Forwarded word covers a write to the same slot in the read cycle
	assign cur_word  = fwd_s1 ? fwd_word_s1 : rd_word;

	assign ram_we    = clr_busy_q || adv_s1;
	assign ram_waddr = clr_busy_q ? clr_cnt_q : slot_s1;
	assign ram_wdata = clr_busy_q ? '0 : new_word;

	dmwb_tag_ram #(
		.DEPTH (SETS),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (req_fire),
		.raddr (req_slot),
		.rdata (rd_word)
	);

	dmwb_update #(
		.SLOT_W     (SLOT_W),
		.TAG_W      (TAG_W),
		.BLOCK_BITS (BLOCK_BITS)
	) u_upd (
		.cmd      (cmd_s1),
		.req_tag  (tag_s1),
		.slot     (slot_s1),
		.old_word (cur_word),
		.flags    (upd_flags),
		.wb_block (upd_wb_block),
		.new_word (new_word)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == SLOT_W'(SETS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1      <= cmd;
			slot_s1     <= req_slot;
			tag_s1      <= req_tag;
			fwd_s1      <= adv_s1 && (slot_s1 == req_slot);
			fwd_word_s1 <= new_word;
		end
		if (adv_s1) begin
			hit_q       <= upd_flags.hit;
			slot_q      <= slot_s1;
			writeback_q <= upd_flags.writeback;
			wb_block_q  <= upd_wb_block;
			fetch_q     <= upd_flags.fetch;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign hit             = hit_q;
	assign slot            = slot_q;
	assign writeback       = writeback_q;
	assign writeback_block = wb_block_q;
	assign fetch           = fetch_q;

endmodule

FILE: hw/rtl/dmwb_tag_ram.sv
// Line store of the tag controller: one write port, one registered read port.
// Word layout is set by the user: {valid, dirty, tag}. Uses dmwb_pkg.
module dmwb_tag_ram
	import dmwb_pkg::*;
#(
	parameter int DEPTH = SETS_DEF,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read-during-write returns the old word; the caller forwards.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/dmwb_update.sv
// Per-command line update: hit test, eviction, fetch and new line word.
// Purely combinational. Uses dmwb_pkg.
module dmwb_update
	import dmwb_pkg::*;
#(
	parameter int SLOT_W     = 15,
	parameter int TAG_W      = 8,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
	input  logic [CMD_W-1:0]      cmd,
	input  logic [TAG_W-1:0]      req_tag,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [TAG_W+1:0]      old_word,
	output dmwb_flags_t           flags,
	output logic [BLOCK_BITS-1:0] wb_block,
	output logic [TAG_W+1:0]      new_word
);

	logic             old_valid;
	logic             old_dirty;
	logic [TAG_W-1:0] old_tag;
	logic             match;
	logic [BLOCK_BITS-1:0] old_blk;

	assign old_valid = old_word[TAG_W+1];
	assign old_dirty = old_word[TAG_W];
	assign old_tag   = old_word[TAG_W-1:0];
	assign match     = old_valid && (old_tag == req_tag);
	// Block held by the line; on a hit this equals the requested block
	assign old_blk   = (BLOCK_BITS'(old_tag) << SLOT_W) | BLOCK_BITS'(slot);

	always_comb begin
		flags.hit       = match;
		flags.writeback = 1'b0;
		flags.fetch     = 1'b0;
		new_word        = old_word;
		unique case (cmd)
			CMD_READ, CMD_WRITE: begin
				if (!match) begin
					flags.writeback = old_valid && old_dirty;
					flags.fetch     = (cmd == CMD_READ);
					new_word        = {1'b1, (cmd == CMD_WRITE), req_tag};
				end else if (cmd == CMD_WRITE) begin
					new_word[TAG_W] = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (match) begin
					new_word[TAG_W+1] = 1'b0;
					new_word[TAG_W]   = 1'b0;
				end
			end
			CMD_SYNC: begin
				if (match && old_dirty) begin
					flags.writeback = 1'b1;
					new_word[TAG_W] = 1'b0;
				end
			end
			default: begin
				new_word = old_word;
			end
		endcase
		wb_block = flags.writeback ? old_blk : '0;
	end

endmodule

FILE: hw/rtl/dmwb_checker.sv
// Port-level checks for the tag controller, bound to the top level.
// Uses dmwb_pkg for default sizes.
module dmwb_checker
	import dmwb_pkg::*;
#(
	parameter int SETS       = SETS_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic [CMD_W-1:0]        cmd,
	input logic [BLOCK_BITS-1:0]   block,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic                    hit,
	input logic [$clog2(SETS)-1:0] slot,
	input logic                    writeback,
	input logic [BLOCK_BITS-1:0]   writeback_block,
	input logic                    fetch
);

	localparam int SLOT_W = $clog2(SETS);

	// A stalled response transfer keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(slot)
			&& $stable(writeback) && $stable(writeback_block) && $stable(fetch))
		else $error("response changed while stalled");

	a_fetch_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fetch |-> !hit)
		else $error("fetch on a hit");

	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !writeback |-> writeback_block == '0)
		else $error("write-back block set without write-back");

	a_wb_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && writeback |-> writeback_block[SLOT_W-1:0] == slot)
		else $error("write-back block maps to another slot");

endmodule

bind direct_mapped_writeback_tag_controller_unit dmwb_checker #(
	.SETS       (SETS),
	.BLOCK_BITS (BLOCK_BITS)
) u_dmwb_checker (.*);
